// File: sv/tgarle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types, constants and helpers for the tga run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    localparam int unsigned CFG_AW = 4;

    typedef enum logic [1:0] {
        REG_BYTES_PER_PIXEL  = 2'd0,
        REG_RUN_LENGTH_CODED = 2'd1,
        REG_KEEP_ALPHA       = 2'd2
    } t_reg_idx;

    localparam logic [2:0] SIZE_MIN  = 3'd2;
    localparam logic [2:0] SIZE_RGB  = 3'd3;
    localparam logic [2:0] SIZE_MAX  = 3'd4;
    localparam logic [6:0] HDR_COUNT_MASK = 7'h7f;

    // assembled source pixel travelling from front to back
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      size;
        logic [7:0]      repeat_count;
    } t_pix_word;

    function automatic logic [7:0] widen5(input logic [4:0] c);
        widen5 = {c, c[4:2]};
    endfunction

endpackage
`default_nettype wire

// File: sv/tgarle_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgarle_front
// Accepts data bytes, tracks packet headers and assembles source pixels.
// ----------------------------------------------------------------------------
module tgarle_front import tgarle_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [2:0]  i_bytes_per_pixel,
    input  wire logic        i_run_length_coded,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_image_start,
    output logic             o_push,
    output t_pix_word        o_word
);

    logic [7:0]      r_remaining, n_remaining;
    logic            r_is_run, n_is_run;
    logic [1:0]      r_bip, n_bip;
    logic [7:0]      r_bytes [4];

    logic [7:0] rem_eff;
    logic       run_eff;
    logic [1:0] bip_eff;
    logic [2:0] size;
    logic       header;
    logic       done;

    always_comb begin
        if (i_bytes_per_pixel < SIZE_MIN) begin
            size = SIZE_MIN;
        end else if (i_bytes_per_pixel > SIZE_MAX) begin
            size = SIZE_MAX;
        end else begin
            size = i_bytes_per_pixel;
        end
    end

    always_comb begin
        rem_eff = i_image_start ? 8'd0 : r_remaining;
        run_eff = i_image_start ? 1'b0 : r_is_run;
        bip_eff = i_image_start ? 2'd0 : r_bip;
        header  = i_run_length_coded && (rem_eff == 8'd0);
        done    = ({1'b0, bip_eff} + 3'd1) >= size;

        n_remaining = rem_eff;
        n_is_run    = run_eff;
        n_bip       = bip_eff;
        o_push      = 1'b0;
        o_word.size = size;
        o_word.repeat_count = 8'd1;
        for (int k = 0; k < 4; k++) begin
            o_word.bytes[k] = (2'(k) == bip_eff) ? i_data_byte : r_bytes[k];
        end

        if (header) begin
            n_remaining = {1'b0, i_data_byte[6:0] & HDR_COUNT_MASK} + 8'd1;
            n_is_run    = i_data_byte[7];
            n_bip       = 2'd0;
        end else if (!done) begin
            n_bip = bip_eff + 2'd1;
        end else begin
            n_bip  = 2'd0;
            o_push = i_accept;
            if (i_run_length_coded) begin
                if (run_eff) begin
                    o_word.repeat_count = rem_eff;
                    n_remaining = 8'd0;
                end else begin
                    n_remaining = rem_eff - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 8'd0;
            r_is_run    <= 1'b0;
            r_bip       <= 2'd0;
        end else if (i_accept) begin
            r_remaining <= n_remaining;
            r_is_run    <= n_is_run;
            r_bip       <= n_bip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !header) begin
            r_bytes[bip_eff] <= i_data_byte;
        end
    end

endmodule
`default_nettype wire

// File: sv/tgarle_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgarle_queue
// Two-word queue between pixel assembly and pixel conversion.
// ----------------------------------------------------------------------------
module tgarle_queue import tgarle_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_pix_word  i_word,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_valid,
    output t_pix_word       o_word
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    t_pix_word         r_mem [DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

endmodule
`default_nettype wire

// File: sv/tgarle_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgarle_back
// Converts queued source pixels to rgb(a) and holds the output register.
// ----------------------------------------------------------------------------
module tgarle_back import tgarle_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_keep_alpha,
    input  wire logic       i_q_valid,
    input  wire t_pix_word  i_q_word,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic [7:0]      o_alpha,
    output logic            o_has_alpha,
    output logic [7:0]      o_repeat_count
);

    logic        r_valid;
    logic [7:0]  r_red, r_green, r_blue, r_alpha, r_rep;
    logic        r_has_alpha;
    logic [7:0]  n_red, n_green, n_blue, n_alpha;
    logic        n_has_alpha;
    logic [15:0] v16;

    assign o_pop = i_q_valid && (!r_valid || !i_stall);
    assign v16   = {i_q_word.bytes[1], i_q_word.bytes[0]};

    always_comb begin
        n_alpha     = 8'd0;
        n_has_alpha = 1'b0;
        if (i_q_word.size == SIZE_MIN) begin
            n_red   = widen5(v16[14:10]);
            n_green = widen5(v16[9:5]);
            n_blue  = widen5(v16[4:0]);
            if (i_keep_alpha) begin
                n_has_alpha = 1'b1;
                n_alpha     = v16[15] ? 8'hff : 8'h00;
            end
        end else begin
            n_red   = i_q_word.bytes[2];
            n_green = i_q_word.bytes[1];
            n_blue  = i_q_word.bytes[0];
            if (i_q_word.size != SIZE_RGB) begin
                n_has_alpha = 1'b1;
                n_alpha     = i_q_word.bytes[3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_red       <= n_red;
            r_green     <= n_green;
            r_blue      <= n_blue;
            r_alpha     <= n_alpha;
            r_has_alpha <= n_has_alpha;
            r_rep       <= i_q_word.repeat_count;
        end
    end

    assign o_valid        = r_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_alpha        = r_alpha;
    assign o_has_alpha    = r_has_alpha;
    assign o_repeat_count = r_rep;

endmodule
`default_nettype wire

// File: sv/tga_rle_pixel_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core
// Decodes the image data section of a tga file into rgb(a) pixel words.
// ----------------------------------------------------------------------------
// One data byte is taken every clock while the pixel queue has room; the
// packet counter and pixel assembly update per byte, so the byte rate is
// one per clock unless the queue is full. A completed pixel enters a
// two-word queue, then the output register; the output side can stall on
// its own until the queue fills. Registers must be written via the apb-style
// port only while no word is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_core import tgarle_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_image_start,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue,
    output logic [7:0]             o_alpha,
    output logic                   o_has_alpha,
    output logic [7:0]             o_repeat_count
);

    logic [2:0] r_bytes_per_pixel;
    logic       r_run_length_coded;
    logic       r_keep_alpha;
    logic       cfg_wr;
    t_reg_idx   cfg_idx;

    logic       in_accept;
    logic       push;
    t_pix_word  push_word;
    logic       q_full;
    logic       q_valid;
    logic       pop;
    t_pix_word  q_word;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_per_pixel  <= SIZE_RGB;
            r_run_length_coded <= 1'b1;
            r_keep_alpha       <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BYTES_PER_PIXEL:  r_bytes_per_pixel  <= pwdata[2:0];
                REG_RUN_LENGTH_CODED: r_run_length_coded <= pwdata[0];
                REG_KEEP_ALPHA:       r_keep_alpha       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BYTES_PER_PIXEL:  prdata = {29'd0, r_bytes_per_pixel};
            REG_RUN_LENGTH_CODED: prdata = {31'd0, r_run_length_coded};
            REG_KEEP_ALPHA:       prdata = {31'd0, r_keep_alpha};
            default:              prdata = 32'd0;
        endcase
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    tgarle_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_bytes_per_pixel  (r_bytes_per_pixel),
        .i_run_length_coded (r_run_length_coded),
        .i_accept           (in_accept),
        .i_data_byte        (i_data_byte),
        .i_image_start      (i_image_start),
        .o_push             (push),
        .o_word             (push_word)
    );

    tgarle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_word  (q_word)
    );

    tgarle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_keep_alpha   (r_keep_alpha),
        .i_q_valid      (q_valid),
        .i_q_word       (q_word),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_has_alpha    (o_has_alpha),
        .o_repeat_count (o_repeat_count)
    );

endmodule
`default_nettype wire

// File: sv/tgarle_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgarle_checker
// Port-level checks for the tga run-length pixel decoder.
// ----------------------------------------------------------------------------
module tgarle_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       pready,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_red,
    input wire logic [7:0] o_green,
    input wire logic [7:0] o_blue,
    input wire logic [7:0] o_alpha,
    input wire logic       o_has_alpha,
    input wire logic [7:0] o_repeat_count
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_red) &&
        $stable(o_green) && $stable(o_blue) && $stable(o_alpha) &&
        $stable(o_has_alpha) && $stable(o_repeat_count))
        else $error("output word changed under stall");

    a_repeat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_repeat_count != 8'd0 && o_repeat_count <= 8'd128)
        else $error("repeat count out of range");

    a_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_alpha |-> o_alpha == 8'd0)
        else $error("alpha set without alpha format");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind tga_rle_pixel_decoder_core tgarle_checker u_tgarle_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .pready         (pready),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_red          (o_red),
    .o_green        (o_green),
    .o_blue         (o_blue),
    .o_alpha        (o_alpha),
    .o_has_alpha    (o_has_alpha),
    .o_repeat_count (o_repeat_count)
);
`default_nettype wire
